/* sv/e2c_pkg.sv */
// shared types, constants and the month length table for the epoch to calendar block
// no dependencies

package e2c_pkg;

   localparam int unsigned SECS_W = 32;
   localparam int unsigned ACC_W  = 33;
   localparam int unsigned DAYS_W = 16;
   localparam int unsigned YEAR_W = 12;

   localparam logic [ACC_W-1:0] SECS_PER_DAY  = 33'd86400;
   localparam logic [ACC_W-1:0] SECS_PER_HOUR = 33'd3600;
   localparam logic [ACC_W-1:0] SECS_PER_MIN  = 33'd60;
   localparam logic [ACC_W-1:0] LEAP_YEAR_LEN = 33'd366;
   localparam logic [ACC_W-1:0] YEAR_LEN      = 33'd365;

   // reciprocals for the time of day split, exact over the operand ranges used
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675), seconds >> 7
   localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225), seconds >> 4
   localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15), seconds >> 2

   localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
   // position of the base year inside the 4, 100 and 400 year cycles
   localparam logic [1:0] BASE_MOD4   = 2'd2;
   localparam logic [6:0] BASE_MOD100 = 7'd70;
   localparam logic [8:0] BASE_MOD400 = 9'd370;
   localparam logic [6:0] LAST_MOD100 = 7'd99;
   localparam logic [8:0] LAST_MOD400 = 9'd399;

   localparam logic [3:0] FEBRUARY = 4'd1;
   localparam logic [3:0] DECEMBER = 4'd11;

   typedef struct packed {
      logic start;
      logic ack;
   } ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } stat_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
   } result_type;

   // days in month, month counted from 0
   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                  len = 5'd30;
         FEBRUARY:                                 len = leap ? 5'd29 : 5'd28;
         default:                                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

/* sv/e2c_if.sv */
// valid/ready channel interfaces for request and response of the calendar block
// depends on e2c_pkg for field widths

interface e2c_req_if;
   logic                         valid;
   logic                         ready;
   logic [e2c_pkg::SECS_W-1:0]   epoch_seconds;

   modport source(output valid, output epoch_seconds, input ready);
   modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface e2c_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [e2c_pkg::YEAR_W-1:0]   year;
   logic [3:0]                   month;
   logic [4:0]                   day;
   logic [4:0]                   hour;
   logic [5:0]                   minute;
   logic [5:0]                   second;

   modport source(output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
   modport sink(input valid, input year, input month, input day,
                input hour, input minute, input second, output ready);
endinterface

/* sv/e2c_alu.sv */
// shared subtract and compare unit of the calendar sequencer
// depends on e2c_pkg

module e2c_alu (
   input  logic [e2c_pkg::ACC_W-1:0] a,
   input  logic [e2c_pkg::ACC_W-1:0] b,
   output logic [e2c_pkg::ACC_W-1:0] diff,
   output logic                      borrow
);

   logic [e2c_pkg::ACC_W:0] full;

   assign full   = {1'b0, a} - {1'b0, b};
   assign diff   = full[e2c_pkg::ACC_W-1:0];
   assign borrow = full[e2c_pkg::ACC_W];

endmodule

/* sv/e2c_core.sv */
// sequencer of the calendar conversion: reciprocal time of day split, year walk, month walk
// depends on e2c_pkg and e2c_alu

module e2c_core (
   input  logic                       clock,
   input  logic                       reset,
   input  e2c_pkg::ctl_type           ctl,
   input  logic [e2c_pkg::SECS_W-1:0] epoch_seconds,
   output e2c_pkg::stat_type          stat,
   output e2c_pkg::result_type        result
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DAYS  = 4'd1;
   localparam logic [3:0] ST_TOD   = 4'd2;
   localparam logic [3:0] ST_HOUR  = 4'd3;
   localparam logic [3:0] ST_HREM  = 4'd4;
   localparam logic [3:0] ST_MIN   = 4'd5;
   localparam logic [3:0] ST_SEC   = 4'd6;
   localparam logic [3:0] ST_YEAR  = 4'd7;
   localparam logic [3:0] ST_MONTH = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0]                        state_ff, state_in;
   logic [e2c_pkg::SECS_W-1:0]        rem_ff, rem_in;
   logic [e2c_pkg::DAYS_W-1:0]        days_ff, days_in;
   logic [4:0]                        hour_ff, hour_in;
   logic [5:0]                        minute_ff, minute_in;
   logic [5:0]                        second_ff, second_in;
   logic [e2c_pkg::YEAR_W-1:0]        year_ff, year_in;
   logic [1:0]                        mod4_ff, mod4_in;
   logic [6:0]                        mod100_ff, mod100_in;
   logic [8:0]                        mod400_ff, mod400_in;
   logic [3:0]                        mon_ff, mon_in;

   logic [e2c_pkg::ACC_W-1:0]         alu_a, alu_b, alu_diff;
   logic                              alu_borrow;
   logic                              leap;
   logic [50:0]                       day_prod;
   logic [25:0]                       hour_prod;
   logic [19:0]                       min_prod;

   e2c_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   assign leap = (mod4_ff == 2'd0) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));

   // quotients by reciprocal multiplication, the remainders go through the subtractor
   assign day_prod  = {26'd0, rem_ff[31:7]} * {25'd0, e2c_pkg::DAY_RECIP};
   assign hour_prod = {13'd0, rem_ff[16:4]} * {12'd0, e2c_pkg::HOUR_RECIP};
   assign min_prod  = {10'd0, rem_ff[11:2]} * {9'd0, e2c_pkg::MIN_RECIP};

   // operands of the shared unit for each step
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff) inside
         ST_TOD: begin
            alu_a = {1'b0, rem_ff};
            alu_b = {17'd0, days_ff} * e2c_pkg::SECS_PER_DAY;
         end
         ST_HREM: begin
            alu_a = {1'b0, rem_ff};
            alu_b = {28'd0, hour_ff} * e2c_pkg::SECS_PER_HOUR;
         end
         ST_SEC: begin
            alu_a = {1'b0, rem_ff};
            alu_b = {27'd0, minute_ff} * e2c_pkg::SECS_PER_MIN;
         end
         ST_YEAR: begin
            alu_a = {{(e2c_pkg::ACC_W-e2c_pkg::DAYS_W){1'b0}}, days_ff};
            alu_b = leap ? e2c_pkg::LEAP_YEAR_LEN : e2c_pkg::YEAR_LEN;
         end
         ST_MONTH: begin
            alu_a = {{(e2c_pkg::ACC_W-e2c_pkg::DAYS_W){1'b0}}, days_ff};
            alu_b = {{(e2c_pkg::ACC_W-5){1'b0}}, e2c_pkg::month_days(mon_ff, leap)};
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      mon_in    = mon_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (ctl.start) begin
               rem_in    = epoch_seconds;
               year_in   = e2c_pkg::BASE_YEAR;
               mod4_in   = e2c_pkg::BASE_MOD4;
               mod100_in = e2c_pkg::BASE_MOD100;
               mod400_in = e2c_pkg::BASE_MOD400;
               mon_in    = '0;
               state_in  = ST_DAYS;
            end
         end
         ST_DAYS: begin
            days_in  = day_prod[50:35];
            state_in = ST_TOD;
         end
         ST_TOD: begin
            rem_in   = alu_diff[e2c_pkg::SECS_W-1:0];
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            hour_in  = hour_prod[25:21];
            state_in = ST_HREM;
         end
         ST_HREM: begin
            rem_in   = alu_diff[e2c_pkg::SECS_W-1:0];
            state_in = ST_MIN;
         end
         ST_MIN: begin
            minute_in = min_prod[19:14];
            state_in  = ST_SEC;
         end
         ST_SEC: begin
            second_in = alu_diff[5:0];
            state_in  = ST_YEAR;
         end
         ST_YEAR: begin
            if (alu_borrow) begin
               state_in = ST_MONTH;
            end else begin
               days_in   = alu_diff[e2c_pkg::DAYS_W-1:0];
               year_in   = year_ff + 12'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == e2c_pkg::LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == e2c_pkg::LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
            end
         end
         ST_MONTH: begin
            // december takes whatever days are left
            if (alu_borrow || (mon_ff == e2c_pkg::DECEMBER)) begin
               state_in = ST_DONE;
            end else begin
               days_in = alu_diff[e2c_pkg::DAYS_W-1:0];
               mon_in  = mon_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      mon_ff    <= mon_in;
   end

   assign stat.idle     = (state_ff == ST_IDLE);
   assign stat.done     = (state_ff == ST_DONE);
   assign result.year   = year_ff;
   assign result.month  = mon_ff + 4'd1;
   assign result.day    = days_ff[4:0] + 5'd1;
   assign result.hour   = hour_ff;
   assign result.minute = minute_ff;
   assign result.second = second_ff;

   a_month_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (mon_ff <= e2c_pkg::DECEMBER))
      else $error("month walk ran past december");

   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (year_ff >= e2c_pkg::BASE_YEAR && year_ff <= 12'd2106))
      else $error("year out of range");

   a_days_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (days_ff <= 16'd30))
      else $error("day of month out of range");

endmodule

/* sv/epoch_seconds_to_calendar_top.sv */
// epoch seconds to calendar date: after a request transfer, states DAYS, TOD, HOUR, HREM,
// MIN and SEC split off days, hour, minute and second by reciprocal multiplication and
// subtraction, then the year walk steps over the elapsed years (up to 136), the month walk
// over the months passed (up to 11), then the done state; no new request until idle again
// the result sits in an output register, so the next transfer is taken while it waits
// reset is synchronous, active high, and clears the sequencer and the output valid
// depends on e2c_pkg, e2c_if, e2c_core

module epoch_seconds_to_calendar_top (
   input  logic       clock,
   input  logic       reset,
   e2c_req_if.sink    req_ch,
   e2c_rsp_if.source  rsp_ch
);

   e2c_pkg::ctl_type    ctl;
   e2c_pkg::stat_type   stat;
   e2c_pkg::result_type result;
   e2c_pkg::result_type out_ff;
   logic                out_valid_ff, out_valid_in;
   logic                load;

   e2c_core u_core (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .epoch_seconds (req_ch.epoch_seconds),
      .stat          (stat),
      .result        (result)
   );

   assign req_ch.ready = stat.idle;
   assign load         = stat.done && (!out_valid_ff || rsp_ch.ready);
   assign ctl.start    = req_ch.valid && stat.idle;
   assign ctl.ack      = load;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.year   = out_ff.year;
   assign rsp_ch.month  = out_ff.month;
   assign rsp_ch.day    = out_ff.day;
   assign rsp_ch.hour   = out_ff.hour;
   assign rsp_ch.minute = out_ff.minute;
   assign rsp_ch.second = out_ff.second;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> !req_ch.ready)
      else $error("sequencer still idle after a request transfer");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("loaded result not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |-> !load)
      else $error("pending result overwritten");

   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      !(stat.idle && stat.done))
      else $error("sequencer idle and done at once");

endmodule

/* bench/e2c_checker.sv */
// checker for the epoch to calendar block: watches both channels, predicts every date
// and compares each response field by field in order
// depends on e2c_pkg and the channel interfaces in e2c_if

module e2c_checker (
   input  logic clock,
   input  logic reset,
   e2c_req_if   req_mon,
   e2c_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DAY_SECS  = 86400;
   localparam int unsigned HOUR_SECS = 3600;
   localparam int unsigned MIN_SECS  = 60;
   localparam int unsigned FIRST_YEAR = 1970;
   // index 0 is january
   localparam logic [11:0][4:0] MONTH_LEN = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                              5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

   e2c_pkg::result_type expected_dates [$];

   function automatic bit gregorian_leap(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic e2c_pkg::result_type calendar_from_epoch(
      input logic [e2c_pkg::SECS_W-1:0] secs);
      int unsigned days;
      int unsigned tod;
      int unsigned yr;
      int unsigned mo;
      int unsigned ylen;
      int unsigned mlen;
      int unsigned hr;
      int unsigned mn;
      int unsigned sc;
      e2c_pkg::result_type date;
      days = secs / DAY_SECS;
      tod  = secs % DAY_SECS;
      hr   = tod / HOUR_SECS;
      mn   = (tod % HOUR_SECS) / MIN_SECS;
      sc   = tod % MIN_SECS;
      yr   = FIRST_YEAR;
      ylen = gregorian_leap(yr) ? 366 : 365;
      while (days >= ylen) begin
         days = days - ylen;
         yr   = yr + 1;
         ylen = gregorian_leap(yr) ? 366 : 365;
      end
      // walk stops at december at the latest
      for (mo = 0; mo < 11; mo++) begin
         mlen = MONTH_LEN[mo] + ((mo == 1 && gregorian_leap(yr)) ? 1 : 0);
         if (days < mlen) break;
         days = days - mlen;
      end
      mo   = mo + 1;
      days = days + 1;
      date.year   = yr[e2c_pkg::YEAR_W-1:0];
      date.month  = mo[3:0];
      date.day    = days[4:0];
      date.hour   = hr[4:0];
      date.minute = mn[5:0];
      date.second = sc[5:0];
      return date;
   endfunction

   function automatic int field_mismatch(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin : monitor
      e2c_pkg::result_type want;
      int errs;
      if (reset) begin
         expected_dates.delete();
         fail_count <= 0;
         pending    <= 0;
         checked    <= 0;
      end else begin
         errs = 0;
         // response side first so a date is never matched against its own request edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_dates.size() == 0) begin
               $display("%0t: response with no request waiting, expected none, %s",
                        $time, "actual below");
               $display("   %0d-%0d-%0d %0d:%0d:%0d", rsp_mon.year, rsp_mon.month,
                        rsp_mon.day, rsp_mon.hour, rsp_mon.minute, rsp_mon.second);
               errs = 1;
            end else begin
               want = expected_dates.pop_front();
               errs += field_mismatch("year", want.year, rsp_mon.year);
               errs += field_mismatch("month", want.month, rsp_mon.month);
               errs += field_mismatch("day", want.day, rsp_mon.day);
               errs += field_mismatch("hour", want.hour, rsp_mon.hour);
               errs += field_mismatch("minute", want.minute, rsp_mon.minute);
               errs += field_mismatch("second", want.second, rsp_mon.second);
               checked <= checked + 1;
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_dates.push_back(calendar_from_epoch(req_mon.epoch_seconds));
         fail_count <= fail_count + errs;
         pending    <= expected_dates.size();
      end
   end

endmodule

/* bench/tb_top.sv */
// top of the epoch to calendar bench: clock, reset, request and response traffic, verdict
// depends on e2c_pkg, e2c_if, the block top and e2c_checker

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 200;
   localparam int PHASE_ITEMS  = 320;
   localparam logic [e2c_pkg::SECS_W-1:0] ALL_ONES = '1;

   logic clock;
   logic reset;
   bit   steady;
   int   sent;
   int   fail_count;
   int   pending;
   int   checked;

   e2c_req_if req_bus ();
   e2c_rsp_if rsp_bus ();

   epoch_seconds_to_calendar_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   e2c_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // holds valid across back to back transfers, lowers it only for a gap
   task automatic send_epoch(input logic [e2c_pkg::SECS_W-1:0] secs);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.epoch_seconds <= secs;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // the checker's count is registered, so it settles after the last transfer; waits until no date is pending
   task automatic drain_dates();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [e2c_pkg::SECS_W-1:0] random_epoch();
      longint base;
      int unsigned yr;
      int unsigned leaps;
      case ($urandom_range(0, 9))
         5, 6: begin
            // around midnight
            base = longint'($urandom_range(0, 49710)) * 86400;
            case ($urandom_range(0, 3))
               0: base = base;
               1: base = base - 1;
               2: base = base + $urandom_range(0, 3599);
               default: base = base + 86399 - $urandom_range(0, 3599);
            endcase
         end
         7: begin
            // around new year, the end of february, the end of the year and january midnights, in a random year
            yr = $urandom_range(1970, 2106);
            leaps = ((yr - 1) / 4 - 492) - ((yr - 1) / 100 - 19) + ((yr - 1) / 400 - 4);
            base = (longint'(yr - 1970) * 365 + leaps) * 86400;
            case ($urandom_range(0, 3))
               0: base = base + $urandom_range(0, 3 * 86400) - 86400;
               1: base = base + 58 * 86400 + $urandom_range(0, 2 * 86400);
               2: base = base + 364 * 86400 + $urandom_range(0, 86400);
               default: base = base + $urandom_range(0, 31) * 86400 - 1;
            endcase
         end
         8: base = ALL_ONES - $urandom_range(0, 40 * 86400);
         9: begin
            base = longint'(1) << $urandom_range(0, 31);
            if ($urandom_range(0, 1)) base = ~base;
         end
         default: base = $urandom;
      endcase
      return base[e2c_pkg::SECS_W-1:0];
   endfunction

   initial begin : result_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top failed");
      $finish;
   end

   initial begin : stimulus
      logic [e2c_pkg::SECS_W-1:0] boundary_secs [$];
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.epoch_seconds <= '0;
      steady = 1'b0;
      sent   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // epoch start, unit rollovers, leap days, century years, signed 32 bit limit, top
      boundary_secs = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
                        32'd86400, 32'd68169600, 32'd94694399, 32'd94694400,
                        32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
                        32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
                        32'hAAAA_AAAA, 32'h5555_5555, ALL_ONES};
      foreach (boundary_secs[i]) send_epoch(boundary_secs[i]);
      drain_dates();

      repeat (PHASE_ITEMS) send_epoch(random_epoch());
      drain_dates();

      // no idling on either side
      steady = 1'b1;
      repeat (PHASE_ITEMS / 2) send_epoch(random_epoch());
      drain_dates();
      steady = 1'b0;

      repeat (PHASE_ITEMS + PHASE_ITEMS / 2) send_epoch(random_epoch());
      drain_dates();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d epoch values (edge cases, random with and without idling)", sent);
      $display("%0d dates checked, mismatches and stray responses: %0d", checked, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
